>>> rtl/kqt_pkg.sv
// Package for the keyed quantity table: entry type, command and status codes.
`default_nettype none
package kqt_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned QtyW = 32;
  localparam int unsigned CmdW = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned EntriesW = 8;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [QtyW-1:0] qty;
  } entry_t;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_ADJUST = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_SORT   = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  localparam logic [QtyW-1:0] QtyMax = {1'b0, {(QtyW-1){1'b1}}};

endpackage
`default_nettype wire

>>> rtl/kqt_cell.sv
// One table cell: holds an entry and loads its neighbor's entry on a shift.
`default_nettype none
module kqt_cell
  import kqt_pkg::*;
(
  input  wire    clk_i,
  input  wire    shift_i,
  input  entry_t next_i,
  output entry_t entry_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= next_i;
    end
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

>>> rtl/kqt_chain.sv
// Chain of table cells fed at the tail; entries move one cell toward the head per shift.
`default_nettype none
module kqt_chain
  import kqt_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  wire    clk_i,
  input  wire    shift_i,
  input  entry_t feed_i,
  output entry_t head_o,
  output entry_t second_o
);

  entry_t cell_out [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t next;
    if (g == DEPTH - 1) begin : g_tail
      assign next = feed_i;
    end else begin : g_body
      assign next = cell_out[g+1];
    end
    kqt_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_i),
      .next_i  (next),
      .entry_o (cell_out[g])
    );
  end

  assign head_o   = cell_out[0];
  assign second_o = cell_out[1];

endmodule
`default_nettype wire

>>> rtl/keyed_quantity_table_core.sv
// Top level of the keyed quantity table: command sequencer, cell ring, result register.
//
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid_i/tready_o     tuser: cmd; tdata: key, amount
// m_axis   out  m_axis_tvalid_o/tready_i     tuser: status; tdata: quantity, entries
//
// Insert, lookup, adjust, remove and unknown commands take one pass of the
// ring. Sort makes n-1 passes for n entries, none for fewer than two, then
// realigns the ring; while a command runs the ring shifts one cell per cycle.
// Reset clears the entry count and control; cell contents stay undefined.
// A result waits in the output register while the next command is taken.
`default_nettype none
module keyed_quantity_table_core
  import kqt_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  wire  [63:0]         s_axis_tdata_i,  // key[31:0], amount[63:32]
  input  wire  [CmdW-1:0]     s_axis_tuser_i,  // cmd
  output logic                m_axis_tvalid_o,
  input  wire                 m_axis_tready_i,
  output logic [39:0]         m_axis_tdata_o,  // quantity[31:0], entries[39:32]
  output logic [StatusW-1:0]  m_axis_tuser_o   // status
);

  localparam int unsigned HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [HW-1:0] HLast = HW'(DEPTH - 1);
  localparam logic [CW-1:0] CntFull = CW'(DEPTH);
  localparam logic [CW-1:0] CycLast = CW'(DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_SORT, S_ALIGN, S_RESP} state_e;

  state_e          state_q;
  logic [CmdW-1:0] cmd_q;
  logic [KeyW-1:0] key_q;
  logic [QtyW-1:0] amt_q;
  logic [CW-1:0]   count_q;
  logic [HW-1:0]   h_q;
  logic [CW-1:0]   c_q;
  logic [HW-1:0]   i_q;
  entry_t          m_q;
  logic            found_q;
  logic [QtyW-1:0] res_qty_q;
  status_e         res_st_q;
  logic            out_valid_q;
  logic [QtyW-1:0] out_qty_q;
  logic [CW-1:0]   out_cnt_q;
  status_e         out_st_q;

  entry_t          head, second, feed;
  logic            shift;
  logic            seek, in_live, hit, swap, full, out_free;
  logic [QtyW:0]   sum;
  logic [QtyW-1:0] adj;
  logic [HW-1:0]   h_next;
  logic [CW:0]     i_plus2;

  assign seek     = (cmd_q == CMD_LOOKUP) || (cmd_q == CMD_ADJUST) || (cmd_q == CMD_REMOVE);
  assign in_live  = CW'(h_q) < count_q;
  assign hit      = seek && in_live && !found_q && (head.key == key_q);
  assign full     = count_q == CntFull;
  assign sum      = {head.qty[QtyW-1], head.qty} + {amt_q[QtyW-1], amt_q};
  assign adj      = sum[QtyW] ? '0 : (sum[QtyW-1] ? QtyMax : sum[QtyW-1:0]);
  assign swap     = (h_q > i_q) && in_live && ($signed(m_q.qty) > $signed(head.qty));
  assign h_next   = (h_q == HLast) ? '0 : h_q + 1'b1;
  assign i_plus2  = (CW+1)'(i_q) + (CW+1)'(2);
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    feed  = head;
    shift = 1'b0;
    unique case (state_q)
      S_RUN: begin
        shift = 1'b1;
        priority case (cmd_q)
          CMD_INSERT: if (CW'(h_q) == count_q && !full) feed = '{key: key_q, qty: amt_q};
          CMD_ADJUST: if (hit) feed = '{key: head.key, qty: adj};
          CMD_REMOVE: if (hit || found_q) feed = second;
          default:    feed = head;
        endcase
      end
      S_SORT: begin
        shift = 1'b1;
        if (c_q == CycLast) begin
          feed = m_q;
        end else if (c_q != '0 && swap) begin
          feed = m_q;
        end
      end
      S_ALIGN: shift = h_q != '0;
      default: shift = 1'b0;
    endcase
  end

  kqt_chain #(.DEPTH(DEPTH)) u_chain (
    .clk_i    (clk_i),
    .shift_i  (shift),
    .feed_i   (feed),
    .head_o   (head),
    .second_o (second)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      h_q         <= '0;
      c_q         <= '0;
      i_q         <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (shift) h_q <= h_next;
      if (m_axis_tready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            cmd_q     <= s_axis_tuser_i;
            key_q     <= s_axis_tdata_i[31:0];
            amt_q     <= s_axis_tdata_i[63:32];
            c_q       <= '0;
            i_q       <= '0;
            found_q   <= 1'b0;
            res_qty_q <= '0;
            res_st_q  <= ST_OK;
            if (s_axis_tuser_i == CMD_SORT) begin
              state_q <= (count_q < CW'(2)) ? S_RESP : S_SORT;
            end else begin
              state_q <= S_RUN;
            end
          end
        end
        S_RUN: begin
          c_q <= c_q + 1'b1;
          if (hit) begin
            found_q   <= 1'b1;
            res_qty_q <= (cmd_q == CMD_ADJUST) ? adj : head.qty;
          end
          if (c_q == CycLast - 1'b1) begin
            state_q <= S_RESP;
            priority case (cmd_q)
              CMD_INSERT: begin
                if (full) begin
                  res_st_q <= ST_FULL;
                end else begin
                  res_qty_q <= amt_q;
                  count_q   <= count_q + 1'b1;
                end
              end
              CMD_LOOKUP, CMD_ADJUST: if (!(hit || found_q)) res_st_q <= ST_MISSING;
              CMD_REMOVE: begin
                if (hit || found_q) count_q <= count_q - 1'b1;
                else res_st_q <= ST_MISSING;
              end
              default: res_st_q <= ST_OK;
            endcase
          end
        end
        S_SORT: begin
          if (c_q == '0) begin
            m_q <= head;
            c_q <= c_q + 1'b1;
          end else if (c_q == CycLast) begin
            c_q <= '0;
            i_q <= i_q + 1'b1;
            if (i_plus2 >= (CW+1)'(count_q)) state_q <= S_ALIGN;
          end else begin
            if (swap) m_q <= head;
            c_q <= c_q + 1'b1;
          end
        end
        S_ALIGN: if (h_q == '0) state_q <= S_RESP;
        S_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_qty_q   <= res_qty_q;
            out_st_q    <= res_st_q;
            out_cnt_q   <= count_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {EntriesW'(out_cnt_q), out_qty_q};
  assign m_axis_tuser_o  = out_st_q;

endmodule
`default_nettype wire

>>> rtl/kqt_checker.sv
// Port-level assertions for the keyed quantity table, bound to the top level.
`default_nettype none
module kqt_assertions
  import kqt_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                s_axis_tvalid_i,
  input wire                s_axis_tready_o,
  input wire                m_axis_tvalid_o,
  input wire                m_axis_tready_i,
  input wire [39:0]         m_axis_tdata_o,
  input wire [StatusW-1:0]  m_axis_tuser_o
);

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("command taken while another in progress");

  a_full_no_qty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_FULL || m_axis_tuser_o == ST_MISSING)
      |-> m_axis_tdata_o[31:0] == '0)
    else $error("nonzero quantity with error status");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (DEPTH >= 256) || (32'(m_axis_tdata_o[39:32]) <= DEPTH))
    else $error("entry count above depth");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

endmodule

bind keyed_quantity_table_core kqt_assertions #(.DEPTH(DEPTH)) u_kqt_assertions (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire
